// ----- src/stuffed_frame_receiver_assert.svh -----
// Assertion macros used by the checker file of the stuffed frame receiver.
`ifndef STUFFED_FRAME_RECEIVER_ASSERT_SVH
`define STUFFED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stuffed_frame_receiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stuffed_frame_receiver: next-cycle check failed");

`endif

// ----- src/sfr_pkg.sv -----
// Package with register indexes, parse phases and result types of the frame receiver.
package sfr_pkg;

   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FLAG_BYTE           = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_BYTE        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_SEQ_ZERO    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_SEQ_ONE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_BYTE         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPED_FLAG_CODE   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPED_ESCAPE_CODE = 3'd6;

   localparam logic [7:0] RESET_FLAG_BYTE           = 8'd126;
   localparam logic [7:0] RESET_ADDRESS_BYTE        = 8'd3;
   localparam logic [7:0] RESET_CONTROL_SEQ_ZERO    = 8'd0;
   localparam logic [7:0] RESET_CONTROL_SEQ_ONE     = 8'd64;
   localparam logic [7:0] RESET_ESCAPE_BYTE         = 8'd125;
   localparam logic [7:0] RESET_ESCAPED_FLAG_CODE   = 8'd94;
   localparam logic [7:0] RESET_ESCAPED_ESCAPE_CODE = 8'd93;

   // Reply kind: upper bit selects REJ, lower bit is the sequence asked for.
   localparam logic REPLY_RR  = 1'b0;
   localparam logic REPLY_REJ = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_FLAG = 3'd1,
      PH_ADDR = 3'd2,
      PH_CTRL = 3'd3,
      PH_DATA = 3'd4,
      PH_ESC  = 3'd5
   } phase_type;

   typedef struct packed {
      logic       is_frame_end;
      logic [7:0] data_byte;
      logic       frame_accepted;
      logic       duplicate_frame;
      logic       check_error;
      logic       stuffing_error;
      logic [1:0] reply_kind;
      logic       frame_sequence;
   } rsp_type;

endpackage

// ----- src/stuffed_frame_receiver.sv -----
// Byte-stuffed stop-and-wait frame receiver: header check, destuffing and frame verdict.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_rx_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_is_frame_end, rsp_data_byte, verdict flags
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One byte a cycle unless a result stalls: a byte waits in the input register, is
// parsed there and, if it yields a result, lands in the result register as it leaves.
// The input register keeps taking bytes while a result waits, until a byte that would
// yield a second result finds the result register still full.
// Reset is synchronous; it restores the register defaults and restarts the flag hunt.
// Configuration writes are always taken (csr_ready is high).
module stuffed_frame_receiver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_is_frame_end,
   output logic [7:0]                        rsp_data_byte,
   output logic                              rsp_frame_accepted,
   output logic                              rsp_duplicate_frame,
   output logic                              rsp_check_error,
   output logic                              rsp_stuffing_error,
   output logic [1:0]                        rsp_reply_kind,
   output logic                              rsp_frame_sequence,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_wdata
);
   import sfr_pkg::*;

   // Configuration registers.
   logic [7:0] flag_ff, address_ff, ctl_zero_ff, ctl_one_ff;
   logic [7:0] escape_ff, esc_flag_ff, esc_escape_ff;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Parser state.
   phase_type  phase_ff, phase_in;
   logic       frame_seq_ff, frame_seq_in;
   logic       expected_seq_ff, expected_seq_in;
   logic [7:0] running_xor_ff, running_xor_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       stuff_err_ff, stuff_err_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       advance;
   logic       produces;
   logic       take_data;
   logic [7:0] take_value;
   logic       finish;
   logic       clear_frame;
   logic       note_stuff_err;
   logic       chk_bad, good, acc;
   logic [7:0] ctl_expected;
   logic       is_flag, is_escape;

   assign is_flag      = (in_byte_ff == flag_ff);
   assign is_escape    = (in_byte_ff == escape_ff);
   assign ctl_expected = address_ff ^ (frame_seq_ff ? ctl_one_ff : ctl_zero_ff);

   // Next parse phase.
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (phase_ff)
            PH_HUNT: phase_in = is_flag ? PH_FLAG : PH_HUNT;
            PH_FLAG: begin
               priority if (is_flag)                    phase_in = PH_FLAG;
               else if (in_byte_ff == address_ff)       phase_in = PH_ADDR;
               else                                     phase_in = PH_HUNT;
            end
            PH_ADDR: begin
               priority if (in_byte_ff == ctl_zero_ff)  phase_in = PH_CTRL;
               else if (in_byte_ff == ctl_one_ff)       phase_in = PH_CTRL;
               else if (is_flag)                        phase_in = PH_FLAG;
               else                                     phase_in = PH_HUNT;
            end
            PH_CTRL: phase_in = (in_byte_ff == ctl_expected) ? PH_DATA : PH_HUNT;
            PH_DATA: begin
               priority if (is_flag)                    phase_in = PH_HUNT;
               else if (is_escape)                      phase_in = PH_ESC;
               else                                     phase_in = PH_DATA;
            end
            PH_ESC:  phase_in = PH_DATA;
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // Per-byte actions of the current phase.
   always_comb begin
      take_data      = 1'b0;
      take_value     = in_byte_ff;
      finish         = 1'b0;
      clear_frame    = 1'b0;
      note_stuff_err = 1'b0;
      if (in_valid_ff) begin
         unique case (phase_ff)
            PH_CTRL: clear_frame = (in_byte_ff == ctl_expected);
            PH_DATA: begin
               priority if (is_flag) begin
                  finish = 1'b1;
               end else if (!is_escape) begin
                  take_data = 1'b1;
               end else begin
                  take_data = 1'b0;
               end
            end
            PH_ESC: begin
               priority if (in_byte_ff == esc_flag_ff) begin
                  take_data  = 1'b1;
                  take_value = flag_ff;
               end else if (in_byte_ff == esc_escape_ff) begin
                  take_data  = 1'b1;
                  take_value = escape_ff;
               end else begin
                  note_stuff_err = 1'b1;
               end
            end
            default: begin
               take_data = 1'b0;
            end
         endcase
      end
   end

   assign produces = finish || (take_data && held_valid_ff);
   assign advance  = in_valid_ff && (!produces || !rsp_valid_ff || rsp_ready);

   assign chk_bad = !held_valid_ff || (running_xor_ff != held_byte_ff);
   assign good    = !chk_bad && !stuff_err_ff;
   assign acc     = good && (frame_seq_ff == expected_seq_ff);

   // Frame state updates.
   always_comb begin
      frame_seq_in    = frame_seq_ff;
      expected_seq_in = expected_seq_ff;
      running_xor_in  = running_xor_ff;
      held_byte_in    = held_byte_ff;
      held_valid_in   = held_valid_ff;
      stuff_err_in    = stuff_err_ff;
      if (advance) begin
         if (phase_ff == PH_ADDR) begin
            if (in_byte_ff == ctl_zero_ff) begin
               frame_seq_in = 1'b0;
            end else if (in_byte_ff == ctl_one_ff) begin
               frame_seq_in = 1'b1;
            end
         end
         if (clear_frame || finish) begin
            running_xor_in = '0;
            held_byte_in   = '0;
            held_valid_in  = 1'b0;
            stuff_err_in   = 1'b0;
         end
         if (finish && acc) begin
            expected_seq_in = !expected_seq_ff;
         end
         if (take_data) begin
            if (held_valid_ff) begin
               running_xor_in = running_xor_ff ^ held_byte_ff;
            end
            held_byte_in  = take_value;
            held_valid_in = 1'b1;
         end
         if (note_stuff_err) begin
            stuff_err_in = 1'b1;
         end
      end
   end

   // Result formation: a held data byte or the frame verdict.
   always_comb begin
      rsp_in = '0;
      if (finish) begin
         rsp_in.is_frame_end    = 1'b1;
         rsp_in.frame_accepted  = acc;
         rsp_in.duplicate_frame = good && !acc;
         rsp_in.check_error     = chk_bad;
         rsp_in.stuffing_error  = stuff_err_ff;
         rsp_in.reply_kind      = {good ? REPLY_RR : REPLY_REJ, !frame_seq_ff};
         rsp_in.frame_sequence  = frame_seq_ff;
      end else begin
         rsp_in.data_byte = held_byte_ff;
      end
   end

   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_valid ? 1'b1 : (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && produces) ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_HUNT;
         frame_seq_ff    <= 1'b0;
         expected_seq_ff <= 1'b0;
         running_xor_ff  <= '0;
         held_byte_ff    <= '0;
         held_valid_ff   <= 1'b0;
         stuff_err_ff    <= 1'b0;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         phase_ff        <= phase_in;
         frame_seq_ff    <= frame_seq_in;
         expected_seq_ff <= expected_seq_in;
         running_xor_ff  <= running_xor_in;
         held_byte_ff    <= held_byte_in;
         held_valid_ff   <= held_valid_in;
         stuff_err_ff    <= stuff_err_in;
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && produces) begin
         rsp_ff <= rsp_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff       <= RESET_FLAG_BYTE;
         address_ff    <= RESET_ADDRESS_BYTE;
         ctl_zero_ff   <= RESET_CONTROL_SEQ_ZERO;
         ctl_one_ff    <= RESET_CONTROL_SEQ_ONE;
         escape_ff     <= RESET_ESCAPE_BYTE;
         esc_flag_ff   <= RESET_ESCAPED_FLAG_CODE;
         esc_escape_ff <= RESET_ESCAPED_ESCAPE_CODE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FLAG_BYTE:           flag_ff       <= csr_wdata;
            CSR_ADDRESS_BYTE:        address_ff    <= csr_wdata;
            CSR_CONTROL_SEQ_ZERO:    ctl_zero_ff   <= csr_wdata;
            CSR_CONTROL_SEQ_ONE:     ctl_one_ff    <= csr_wdata;
            CSR_ESCAPE_BYTE:         escape_ff     <= csr_wdata;
            CSR_ESCAPED_FLAG_CODE:   esc_flag_ff   <= csr_wdata;
            CSR_ESCAPED_ESCAPE_CODE: esc_escape_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_frame_end    = rsp_ff.is_frame_end;
   assign rsp_data_byte       = rsp_ff.data_byte;
   assign rsp_frame_accepted  = rsp_ff.frame_accepted;
   assign rsp_duplicate_frame = rsp_ff.duplicate_frame;
   assign rsp_check_error     = rsp_ff.check_error;
   assign rsp_stuffing_error  = rsp_ff.stuffing_error;
   assign rsp_reply_kind      = rsp_ff.reply_kind;
   assign rsp_frame_sequence  = rsp_ff.frame_sequence;

endmodule

// ----- src/sfr_checker.sv -----
// Port checker of the frame receiver and its bind to the top level.
`include "stuffed_frame_receiver_assert.svh"

module sfr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_is_frame_end,
   input logic [7:0]                        rsp_data_byte,
   input logic                              rsp_frame_accepted,
   input logic                              rsp_duplicate_frame,
   input logic                              rsp_check_error,
   input logic                              rsp_stuffing_error,
   input logic [1:0]                        rsp_reply_kind,
   input logic                              rsp_frame_sequence
);

   logic        rsp_stalled;
   logic [15:0] rsp_payload;
   logic        verdict_bits;
   logic        reply_ok;
   logic        good_frame;
   logic        good_flags_ok;

   assign rsp_stalled   = rsp_valid && !rsp_ready;
   assign rsp_payload   = {rsp_is_frame_end, rsp_data_byte, rsp_frame_accepted,
                           rsp_duplicate_frame, rsp_check_error, rsp_stuffing_error,
                           rsp_reply_kind, rsp_frame_sequence};
   assign verdict_bits  = rsp_frame_accepted || rsp_duplicate_frame || rsp_check_error ||
                          rsp_stuffing_error || rsp_frame_sequence ||
                          (rsp_reply_kind != 2'd0);
   assign reply_ok      = (rsp_data_byte == 8'd0) &&
                          (rsp_reply_kind[1] == (rsp_check_error || rsp_stuffing_error)) &&
                          (rsp_reply_kind[0] == !rsp_frame_sequence);
   assign good_frame    = rsp_frame_accepted || rsp_duplicate_frame;
   assign good_flags_ok = !rsp_check_error && !rsp_stuffing_error &&
                          !(rsp_frame_accepted && rsp_duplicate_frame);

   // A stalled result transfer keeps its payload.
   `SFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))

   // A data byte carries no verdict flags.
   `SFR_ASSERT_NOW(a_data_clean, clock, reset, rsp_valid && !rsp_is_frame_end, !verdict_bits)

   // The reply asks for the other sequence and is REJ exactly when an error was seen.
   `SFR_ASSERT_NOW(a_reply_match, clock, reset, rsp_valid && rsp_is_frame_end, reply_ok)

   // Accepted and duplicate frames are error free and never both.
   `SFR_ASSERT_NOW(a_good_exclusive, clock, reset, rsp_valid && good_frame, good_flags_ok)

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (.*);
